/* rtl/core/rlsfs_pkg.sv */
// shared types and constants of the led strip frame serializer
package rlsfs_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int PIX_W      = $clog2(MAX_PIXELS);
    localparam int COUNT_W    = 7;
    localparam int DUTY_W     = 16;
    localparam int ROW_W      = 24;
    localparam int BITPOS_W   = 5;

    localparam logic [BITPOS_W-1:0] BITS_PER_PIXEL = 5'd24;
    localparam logic [BITPOS_W-1:0] HOME_BIT       = 5'd7;

    localparam logic [COUNT_W-1:0] COUNT_RESET     = 7'd29;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 7'(MAX_PIXELS);
    localparam logic [DUTY_W-1:0]  DUTY_ZERO_RESET = 16'h0001;
    localparam logic [DUTY_W-1:0]  DUTY_ONE_RESET  = 16'h000F;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_FILL  = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_TICK  = 3'd3;
    localparam logic [2:0] ACT_SLOT  = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ONE    = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [PIX_W-1:0]   pixel_index;
        logic [COUNT_W-1:0] range_start;
        logic [COUNT_W-1:0] range_stop;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } item_t;

    typedef struct packed {
        logic              duty_valid;
        logic [DUTY_W-1:0] duty_out;
        logic              sending;
        logic [7:0]        read_red;
        logic [7:0]        read_green;
        logic [7:0]        read_blue;
    } result_t;

endpackage

/* rtl/core/rlsfs_ram.sv */
// generic single write port ram with registered read
module rlsfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/rgb_led_strip_frame_serializer.sv */
// led strip frame store and bit serializer, top level
// states: write, tick and idle slot pass exec then done; read and active slot pass exec,
// wait and done; fill passes exec, fill and done, one pixel row written per cycle
// one item in flight; ready again the cycle after its result is loaded
// the frame store is one 64 x 24 bit ram read through a registered port
// reset is synchronous: row valid bits clear at once, so the store reads black
module rgb_led_strip_frame_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rlsfs_pkg::item_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rlsfs_pkg::result_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rlsfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlsfs_pkg::DUTY_W-1:0]   cfg_data
);
    import rlsfs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]      pix_reg, pix_next;
    logic [BITPOS_W-1:0]   bitpos_reg, bitpos_next;
    logic                  dirty_reg, dirty_next;
    logic                  sending_reg, sending_next;
    logic [COUNT_W-1:0]    fill_idx_reg, fill_idx_next;
    logic [COUNT_W-1:0]    fill_end_reg, fill_end_next;
    logic [MAX_PIXELS-1:0] row_valid_reg, row_valid_next;
    logic [PIX_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [COUNT_W-1:0]    pixel_count_reg, pixel_count_next;
    logic [DUTY_W-1:0]     duty_zero_reg, duty_zero_next;
    logic [DUTY_W-1:0]     duty_one_reg, duty_one_next;

    logic                  ram_we;
    logic [PIX_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [PIX_W-1:0]      ram_raddr;
    logic [ROW_W-1:0]      ram_rdata;

    logic [COUNT_W-1:0]    live_count;
    logic [PIX_W-1:0]      wr_pix;
    logic [ROW_W-1:0]      row_data;
    logic [7:0]            cur_byte;
    logic                  cur_bit;
    logic [COUNT_W-1:0]    pix_inc;
    logic [BITPOS_W-1:0]   bit_inc;

    rlsfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (pixel_count_reg == '0) begin
            live_count = 7'd1;
        end else if (pixel_count_reg > COUNT_MAX) begin
            live_count = COUNT_MAX;
        end else begin
            live_count = pixel_count_reg;
        end
    end

    // pixel zero keeps only the two top green bits, swapped and moved down
    always_comb begin
        if (wr_pix == '0) begin
            ram_wdata = {5'b0, item_reg.green_in[6], item_reg.green_in[7], 1'b0,
                         item_reg.red_in, item_reg.blue_in};
        end else begin
            ram_wdata = {item_reg.green_in, item_reg.red_in, item_reg.blue_in};
        end
    end

    assign ram_waddr = wr_pix;
    assign row_data  = row_valid_reg[rd_addr_reg] ? ram_rdata : '0;

    always_comb begin
        case (bitpos_reg[4:3])
            2'd0:    cur_byte = row_data[23:16];
            2'd1:    cur_byte = row_data[15:8];
            2'd2:    cur_byte = row_data[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    assign cur_bit = cur_byte[~bitpos_reg[2:0]];

    always_comb begin
        if (bitpos_reg == BITS_PER_PIXEL - 5'd1) begin
            bit_inc = '0;
            pix_inc = {1'b0, pix_reg} + 7'd1;
        end else begin
            bit_inc = bitpos_reg + 5'd1;
            pix_inc = {1'b0, pix_reg};
        end
    end

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        m_valid_next     = m_valid_reg;
        pix_next         = pix_reg;
        bitpos_next      = bitpos_reg;
        dirty_next       = dirty_reg;
        sending_next     = sending_reg;
        fill_idx_next    = fill_idx_reg;
        fill_end_next    = fill_end_reg;
        row_valid_next   = row_valid_reg;
        rd_addr_next     = rd_addr_reg;
        pixel_count_next = pixel_count_reg;
        duty_zero_next   = duty_zero_reg;
        duty_one_next    = duty_one_reg;
        ram_we           = 1'b0;
        wr_pix           = item_reg.pixel_index;
        ram_raddr        = (item_reg.action == ACT_SLOT) ? pix_reg : item_reg.pixel_index;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_next = cfg_data[COUNT_W-1:0];
                CFG_DUTY_ZERO:   duty_zero_next   = cfg_data;
                CFG_DUTY_ONE:    duty_one_next    = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next     = '0;
                rd_addr_next = ram_raddr;
                state_next   = ST_DONE;
                unique case (item_reg.action)
                    ACT_WRITE: begin
                        ram_we                              = 1'b1;
                        row_valid_next[item_reg.pixel_index] = 1'b1;
                        dirty_next                          = 1'b1;
                    end
                    ACT_FILL: begin
                        fill_idx_next = item_reg.range_start;
                        fill_end_next = (item_reg.range_stop > live_count)
                                        ? live_count : item_reg.range_stop;
                        state_next    = ST_FILL;
                    end
                    ACT_READ: begin
                        state_next = ST_WAIT;
                    end
                    ACT_TICK: begin
                        if (dirty_reg) begin
                            dirty_next   = 1'b0;
                            sending_next = 1'b1;
                        end
                    end
                    ACT_SLOT: begin
                        if (sending_reg) begin
                            state_next = ST_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FILL: begin
                wr_pix = fill_idx_reg[PIX_W-1:0];
                if (fill_idx_reg < fill_end_reg) begin
                    ram_we                 = 1'b1;
                    row_valid_next[wr_pix] = 1'b1;
                    dirty_next             = 1'b1;
                    fill_idx_next          = fill_idx_reg + 7'd1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WAIT: begin
                state_next = ST_DONE;
                if (item_reg.action == ACT_SLOT) begin
                    res_next.duty_valid = 1'b1;
                    res_next.duty_out   = cur_bit ? duty_one_reg : duty_zero_reg;
                    if (pix_inc == '0 && bit_inc == HOME_BIT) begin
                        sending_next = 1'b0;
                    end
                    if (pix_inc >= live_count) begin
                        pix_next    = '0;
                        bitpos_next = '0;
                    end else begin
                        pix_next    = pix_inc[PIX_W-1:0];
                        bitpos_next = bit_inc;
                    end
                end else begin
                    res_next.read_green = row_data[23:16];
                    res_next.read_red   = row_data[15:8];
                    res_next.read_blue  = row_data[7:0];
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next         = res_reg;
                    out_next.sending = sending_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            pix_reg         <= '0;
            bitpos_reg      <= HOME_BIT;
            dirty_reg       <= 1'b1;
            sending_reg     <= 1'b0;
            row_valid_reg   <= '0;
            pixel_count_reg <= COUNT_RESET;
            duty_zero_reg   <= DUTY_ZERO_RESET;
            duty_one_reg    <= DUTY_ONE_RESET;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            pix_reg         <= pix_next;
            bitpos_reg      <= bitpos_next;
            dirty_reg       <= dirty_next;
            sending_reg     <= sending_next;
            row_valid_reg   <= row_valid_next;
            pixel_count_reg <= pixel_count_next;
            duty_zero_reg   <= duty_zero_next;
            duty_one_reg    <= duty_one_next;
        end
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        fill_idx_reg <= fill_idx_next;
        fill_end_reg <= fill_end_next;
        rd_addr_reg  <= rd_addr_next;
    end

endmodule
